>>> hw/rtl/palette_pixel_format_converter_core_assert.svh
// assertion macros for the palette pixel format converter
// used by the rtl modules through `include; depends on nothing else
`ifndef PALETTE_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define PALETTE_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PPFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppfc: same-cycle check failed");

// next-cycle implication, quiet during reset
`define PPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppfc: next-cycle check failed");

`endif

>>> hw/rtl/ppfc_pkg.sv
// shared types, constants, tables and helper functions of the palette converter
// no dependencies; used by every rtl module of the block
`default_nettype none

package ppfc_pkg;

    // geometry
    localparam int PALETTE_ENTRIES_DEFAULT = 256;
    localparam int INDEX_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int DAC_W      = 6;
    localparam int MAX_W      = 16;
    localparam int SHIFT_W    = 5;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 24;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item operations
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_SHIFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SHIFT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SHIFT  = 3'd7;

    // output width codes
    localparam logic [MODE_W-1:0] BPP_ONE  = 2'd0;
    localparam logic [MODE_W-1:0] BPP_TWO  = 2'd1;
    localparam logic [MODE_W-1:0] BPP_FOUR = 2'd2;

    // position of the final byte for each width
    localparam logic [POS_W-1:0] LAST_POS_ONE  = 2'd0;
    localparam logic [POS_W-1:0] LAST_POS_TWO  = 2'd1;
    localparam logic [POS_W-1:0] LAST_POS_FOUR = 2'd3;

    // configuration reset values
    localparam logic [MODE_W-1:0]  RST_BPP_MODE    = BPP_FOUR;
    localparam logic               RST_BIG_ENDIAN  = 1'b0;
    localparam logic [MAX_W-1:0]   RST_CHAN_MAX    = 16'd255;
    localparam logic [SHIFT_W-1:0] RST_RED_SHIFT   = 5'd16;
    localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT = 5'd8;
    localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT  = 5'd0;

    // channel scaling
    localparam logic [PROD_W-1:0] ROUND_BIAS = 24'd127;
    localparam logic [PROD_W-1:0] DIV_CONST  = 24'd255;

    // default palette layout
    localparam logic [INDEX_W-1:0] EGA_END   = 8'd16;
    localparam logic [INDEX_W-1:0] GRAY_END  = 8'd32;
    localparam logic [INDEX_W-1:0] HUE_BASE  = 8'd32;
    localparam logic [INDEX_W-1:0] HUE_END   = 8'd248;
    localparam int                 HUE_STEPS  = 24;
    localparam int                 HUE_GROUPS = 9;

    typedef struct packed {
        logic              op;
        logic [INDEX_W-1:0] color_index;
        logic [DAC_W-1:0]  entry_red;
        logic [DAC_W-1:0]  entry_green;
        logic [DAC_W-1:0]  entry_blue;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] out_byte;
        logic              last_of_pixel;
    } t_out_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [MODE_W-1:0]  bpp_mode;
        logic               big_endian;
        logic [MAX_W-1:0]   red_max;
        logic [MAX_W-1:0]   green_max;
        logic [MAX_W-1:0]   blue_max;
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
    } t_cfg;

    // ega colors, 6-bit dac values r, g, b
    localparam logic [DAC_W-1:0] EGA_TAB [16][3] = '{
        '{ 0,  0,  0}, '{ 0,  0, 42}, '{ 0, 42,  0}, '{ 0, 42, 42},
        '{42,  0,  0}, '{42,  0, 42}, '{42, 21,  0}, '{42, 42, 42},
        '{21, 21, 21}, '{21, 21, 63}, '{21, 63, 21}, '{21, 63, 63},
        '{63, 21, 21}, '{63, 21, 63}, '{63, 63, 21}, '{63, 63, 63}
    };

    // gray ramp
    localparam logic [DAC_W-1:0] GRAY_TAB [16] = '{
        0, 5, 8, 11, 14, 17, 20, 24, 28, 32, 36, 40, 45, 50, 56, 63
    };

    // five levels (floor .. peak) for each peak and saturation group
    localparam logic [DAC_W-1:0] LEVEL_TAB [9][5] = '{
        '{ 0, 16, 31, 47, 63}, '{32, 40, 47, 55, 63}, '{45, 50, 54, 58, 63},
        '{ 0,  7, 14, 21, 28}, '{14, 18, 21, 24, 28}, '{20, 22, 24, 26, 28},
        '{ 0,  4,  8, 12, 16}, '{ 8, 10, 12, 14, 16}, '{11, 12, 13, 14, 16}
    };

    // level index per hue step for r, g, b
    localparam logic [2:0] HUE_TAB [24][3] = '{
        '{0,0,4}, '{1,0,4}, '{2,0,4}, '{3,0,4}, '{4,0,4}, '{4,0,3}, '{4,0,2}, '{4,0,1},
        '{4,0,0}, '{4,1,0}, '{4,2,0}, '{4,3,0}, '{4,4,0}, '{3,4,0}, '{2,4,0}, '{1,4,0},
        '{0,4,0}, '{0,4,1}, '{0,4,2}, '{0,4,3}, '{0,4,4}, '{0,3,4}, '{0,2,4}, '{0,1,4}
    };

    // 6-bit dac value to 8 bits by bit replication
    function automatic logic [CHAN_W-1:0] widen6(input logic [DAC_W-1:0] v);
        widen6 = {v, v[DAC_W-1:DAC_W-2]};
    endfunction

    // reset contents of one palette entry
    function automatic t_rgb default_entry(input logic [INDEX_W-1:0] idx);
        logic [DAC_W-1:0]   dr;
        logic [DAC_W-1:0]   dg;
        logic [DAC_W-1:0]   db;
        logic [INDEX_W-1:0] off;
        logic [3:0]         grp;
        logic [4:0]         k;
        t_rgb               e;
        dr  = '0;
        dg  = '0;
        db  = '0;
        grp = '0;
        k   = '0;
        off = idx - HUE_BASE;
        if (idx < EGA_END) begin
            dr = EGA_TAB[idx[3:0]][0];
            dg = EGA_TAB[idx[3:0]][1];
            db = EGA_TAB[idx[3:0]][2];
        end else if (idx < GRAY_END) begin
            dr = GRAY_TAB[idx[3:0]];
            dg = dr;
            db = dr;
        end else if (idx < HUE_END) begin
            for (int g = 0; g < HUE_GROUPS; g++) begin
                if (off >= INDEX_W'(HUE_STEPS * g)) begin
                    grp = 4'(g);
                    k   = 5'(off - INDEX_W'(HUE_STEPS * g));
                end
            end
            dr = LEVEL_TAB[grp][HUE_TAB[k][0]];
            dg = LEVEL_TAB[grp][HUE_TAB[k][1]];
            db = LEVEL_TAB[grp][HUE_TAB[k][2]];
        end
        e.red   = widen6(dr);
        e.green = widen6(dg);
        e.blue  = widen6(db);
        default_entry = e;
    endfunction

    // floor(x / 255) for x below 255 * 2^16: shift-add estimate, then one correction
    function automatic logic [MAX_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0]    t;
        logic [MAX_W-1:0]   qe;
        logic [PROD_W-1:0]  qm;
        logic [PROD_W-1:0]  rem;
        t   = {1'b0, x} + (PROD_W+1)'(x >> 8) + (PROD_W+1)'(x >> 16);
        qe  = t[PROD_W-1:8];
        qm  = {qe, 8'b0} - PROD_W'(qe);
        rem = x - qm;
        div255 = (rem >= DIV_CONST) ? qe + 1'b1 : qe;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ppfc_palette.sv
// palette store with per-entry written flags and registered read stage
// depends on ppfc_pkg and the assertion header
`default_nettype none

`include "palette_pixel_format_converter_core_assert.svh"

module ppfc_palette #(
    parameter int ENTRIES = ppfc_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire ppfc_pkg::t_in_item i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output ppfc_pkg::t_rgb          o_entry
);

    localparam int AW = $clog2(ENTRIES);

    ppfc_pkg::t_rgb r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_entry_vld;

    logic           r_valid;
    ppfc_pkg::t_rgb r_rd_data;
    ppfc_pkg::t_rgb r_def;
    logic           r_written;
    logic           r_in_range;

    logic           accept;
    logic           in_range;
    logic           wr_hit;
    logic           rd_go;
    logic [AW-1:0]  addr;
    ppfc_pkg::t_rgb new_entry;

    // item decode
    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign addr     = i_item.color_index[AW-1:0];
    assign in_range = {1'b0, i_item.color_index} < (ppfc_pkg::INDEX_W+1)'(ENTRIES);
    assign wr_hit   = accept && (i_item.op == ppfc_pkg::OP_WRITE) && in_range;
    assign rd_go    = accept && (i_item.op == ppfc_pkg::OP_PIXEL);

    assign new_entry.red   = ppfc_pkg::widen6(i_item.entry_red);
    assign new_entry.green = ppfc_pkg::widen6(i_item.entry_green);
    assign new_entry.blue  = ppfc_pkg::widen6(i_item.entry_blue);

    // palette memory, one write or one read per item
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[addr] <= new_entry;
        end
        if (rd_go) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // written flags, cleared by reset so untouched entries read as default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
        end else if (wr_hit) begin
            r_entry_vld[addr] <= 1'b1;
        end
    end

    // lookup side data captured with the read
    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_def      <= ppfc_pkg::default_entry(i_item.color_index);
            r_written  <= r_entry_vld[addr];
            r_in_range <= in_range;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= rd_go;
        end
    end

    // out of range pixels look up black
    assign o_valid = r_valid;
    assign o_entry = !r_in_range ? '0 : (r_written ? r_rd_data : r_def);

    `PPFC_ASSERT_NEXT(a_write_marks_entry, i_clk, i_rst_n, wr_hit, r_entry_vld[$past(addr)])

endmodule

`default_nettype wire

>>> hw/rtl/ppfc_scale.sv
// channel scaling to configured maxima and pixel word assembly, two stages
// depends on ppfc_pkg and the assertion header
`default_nettype none

`include "palette_pixel_format_converter_core_assert.svh"

module ppfc_scale (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ppfc_pkg::t_cfg                i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire ppfc_pkg::t_rgb                i_entry,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ppfc_pkg::WORD_W-1:0]        o_word
);

    logic                          r_p_valid;
    logic [ppfc_pkg::PROD_W-1:0]   r_x_red;
    logic [ppfc_pkg::PROD_W-1:0]   r_x_green;
    logic [ppfc_pkg::PROD_W-1:0]   r_x_blue;
    logic                          r_w_valid;
    logic [ppfc_pkg::WORD_W-1:0]   r_word;

    logic                          p_ready;
    logic                          w_ready;
    logic [ppfc_pkg::PROD_W-1:0]   n_x_red;
    logic [ppfc_pkg::PROD_W-1:0]   n_x_green;
    logic [ppfc_pkg::PROD_W-1:0]   n_x_blue;
    logic [ppfc_pkg::WORD_W-1:0]   n_word;

    assign w_ready = !r_w_valid || i_ready;
    assign p_ready = !r_p_valid || w_ready;
    assign o_ready = p_ready;

    // stage p: channel times maximum plus rounding bias
    assign n_x_red   = ppfc_pkg::PROD_W'(i_entry.red)   * ppfc_pkg::PROD_W'(i_cfg.red_max)
                     + ppfc_pkg::ROUND_BIAS;
    assign n_x_green = ppfc_pkg::PROD_W'(i_entry.green) * ppfc_pkg::PROD_W'(i_cfg.green_max)
                     + ppfc_pkg::ROUND_BIAS;
    assign n_x_blue  = ppfc_pkg::PROD_W'(i_entry.blue)  * ppfc_pkg::PROD_W'(i_cfg.blue_max)
                     + ppfc_pkg::ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_valid && p_ready) begin
            r_x_red   <= n_x_red;
            r_x_green <= n_x_green;
            r_x_blue  <= n_x_blue;
        end
    end

    // stage w: divide by 255, shift into place, merge; high bits fall off
    assign n_word = (ppfc_pkg::WORD_W'(ppfc_pkg::div255(r_x_red))   << i_cfg.red_shift)
                  | (ppfc_pkg::WORD_W'(ppfc_pkg::div255(r_x_green)) << i_cfg.green_shift)
                  | (ppfc_pkg::WORD_W'(ppfc_pkg::div255(r_x_blue))  << i_cfg.blue_shift);

    always_ff @(posedge i_clk) begin
        if (r_p_valid && w_ready) begin
            r_word <= n_word;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_valid;
            end
            if (w_ready) begin
                r_w_valid <= r_p_valid;
            end
        end
    end

    assign o_valid = r_w_valid;
    assign o_word  = r_word;

    `PPFC_ASSERT_NEXT(a_word_holds, i_clk, i_rst_n, r_w_valid && !i_ready, r_w_valid && $stable(r_word))

endmodule

`default_nettype wire

>>> hw/rtl/ppfc_serial.sv
// byte serializer: emits one pixel word as 1, 2 or 4 bytes in either order
// depends on ppfc_pkg and the assertion header
`default_nettype none

`include "palette_pixel_format_converter_core_assert.svh"

module ppfc_serial (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ppfc_pkg::t_cfg          i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [ppfc_pkg::WORD_W-1:0] i_word,
    output logic                         o_valid,
    output ppfc_pkg::t_out_item          o_item,
    input  wire logic                    i_stall
);

    logic                           r_valid;
    logic [ppfc_pkg::POS_W-1:0]     r_cnt;
    logic [ppfc_pkg::POS_W-1:0]     r_last_pos;
    logic                           r_big;
    logic [ppfc_pkg::WORD_W-1:0]    r_word;

    logic                           out_acc;
    logic                           is_last;
    logic                           load;
    logic [ppfc_pkg::POS_W-1:0]     n_last_pos;
    logic [ppfc_pkg::POS_W-1:0]     pos;

    assign out_acc = r_valid && !i_stall;
    assign is_last = (r_cnt == r_last_pos);
    assign o_ready = !r_valid || (out_acc && is_last);
    assign load    = i_valid && o_ready;

    // final byte position from the width code; the unused code means four bytes
    always_comb begin
        case (i_cfg.bpp_mode)
            ppfc_pkg::BPP_ONE: n_last_pos = ppfc_pkg::LAST_POS_ONE;
            ppfc_pkg::BPP_TWO: n_last_pos = ppfc_pkg::LAST_POS_TWO;
            default:           n_last_pos = ppfc_pkg::LAST_POS_FOUR;
        endcase
    end

    // word and format held for the whole pixel
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word     <= i_word;
            r_last_pos <= n_last_pos;
            r_big      <= i_cfg.big_endian;
        end
    end

    // byte counter and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (out_acc) begin
            r_valid <= !is_last;
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    // byte select
    assign pos                  = r_big ? (r_last_pos - r_cnt) : r_cnt;
    assign o_valid              = r_valid;
    assign o_item.out_byte      = r_word[{pos, 3'b000} +: ppfc_pkg::CHAN_W];
    assign o_item.last_of_pixel = is_last;

    `PPFC_ASSERT_NOW(a_cnt_in_range, i_clk, i_rst_n, r_valid, r_cnt <= r_last_pos)
    `PPFC_ASSERT_NEXT(a_bytes_contiguous, i_clk, i_rst_n, out_acc && !is_last, r_valid && (r_cnt == $past(r_cnt) + 2'd1))

endmodule

`default_nettype wire

>>> hw/rtl/palette_pixel_format_converter_core.sv
// Palette pixel format converter. Each input item is either a palette write
// (gives no output) or a pixel, which is looked up in the palette, scaled
// per channel to the configured maximum with rounding, shifted and merged
// into a 32-bit word, and sent as 1, 2 or 4 bytes with a last flag on the
// final byte. The byte serializer sends one byte per cycle while the output
// is not stalled, and loads the next pixel's word as the last byte of the
// current one is taken. A pixel passes the registered steps palette read,
// multiply, divide and merge, and serializer in that order. The palette
// comes out of reset holding the default VGA palette at once: entries not
// yet written read their default value, so there is no clearing pass.
// Configuration registers may be written only while the block is idle.
`default_nettype none

module palette_pixel_format_converter_core #(
    parameter int PALETTE_ENTRIES = ppfc_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [ppfc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ppfc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input item channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire ppfc_pkg::t_in_item                i_in_item,
    // result item channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output ppfc_pkg::t_out_item                    o_out_item
);

    ppfc_pkg::t_cfg              r_cfg;
    logic                        in_ready;
    logic                        rd_valid;
    logic                        sc_ready;
    ppfc_pkg::t_rgb              rd_entry;
    logic                        w_valid;
    logic                        ser_ready;
    logic [ppfc_pkg::WORD_W-1:0] w_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp_mode    <= ppfc_pkg::RST_BPP_MODE;
            r_cfg.big_endian  <= ppfc_pkg::RST_BIG_ENDIAN;
            r_cfg.red_max     <= ppfc_pkg::RST_CHAN_MAX;
            r_cfg.green_max   <= ppfc_pkg::RST_CHAN_MAX;
            r_cfg.blue_max    <= ppfc_pkg::RST_CHAN_MAX;
            r_cfg.red_shift   <= ppfc_pkg::RST_RED_SHIFT;
            r_cfg.green_shift <= ppfc_pkg::RST_GREEN_SHIFT;
            r_cfg.blue_shift  <= ppfc_pkg::RST_BLUE_SHIFT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ppfc_pkg::CFG_BPP_MODE:    r_cfg.bpp_mode    <= i_cfg_wdata[ppfc_pkg::MODE_W-1:0];
                ppfc_pkg::CFG_BIG_ENDIAN:  r_cfg.big_endian  <= i_cfg_wdata[0];
                ppfc_pkg::CFG_RED_MAX:     r_cfg.red_max     <= i_cfg_wdata;
                ppfc_pkg::CFG_GREEN_MAX:   r_cfg.green_max   <= i_cfg_wdata;
                ppfc_pkg::CFG_BLUE_MAX:    r_cfg.blue_max    <= i_cfg_wdata;
                ppfc_pkg::CFG_RED_SHIFT:   r_cfg.red_shift   <= i_cfg_wdata[ppfc_pkg::SHIFT_W-1:0];
                ppfc_pkg::CFG_GREEN_SHIFT: r_cfg.green_shift <= i_cfg_wdata[ppfc_pkg::SHIFT_W-1:0];
                ppfc_pkg::CFG_BLUE_SHIFT:  r_cfg.blue_shift  <= i_cfg_wdata[ppfc_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // palette lookup and writes
    ppfc_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (in_ready),
        .i_item  (i_in_item),
        .o_valid (rd_valid),
        .i_ready (sc_ready),
        .o_entry (rd_entry)
    );

    // scaling and word assembly
    ppfc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (rd_valid),
        .o_ready (sc_ready),
        .i_entry (rd_entry),
        .o_valid (w_valid),
        .i_ready (ser_ready),
        .o_word  (w_word)
    );

    // byte output
    ppfc_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_valid),
        .o_ready (ser_ready),
        .i_word  (w_word),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

    assign o_in_stall = !in_ready;

endmodule

`default_nettype wire

>>> sim/palette_pixel_format_converter_core_tb.sv
// self-checking testbench for palette_pixel_format_converter_core
// depends on ppfc_pkg and the core rtl; holds its own palette and format model
`timescale 1ns / 100ps

module palette_pixel_format_converter_core_tb;
    import ppfc_pkg::*;

    localparam int NUM_ENTRIES     = 256;
    localparam int DIR_ROWS        = 20;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int TAIL_CYCLES     = 8;
    localparam int HOLD_CYCLES     = 120;
    localparam int TIMEOUT_NS      = 2000000;

    // gray ramp dac values, entry 0 in the low bits
    localparam logic [95:0] GRAY_DAC = {
        6'd63, 6'd56, 6'd50, 6'd45, 6'd40, 6'd36, 6'd32, 6'd28,
        6'd24, 6'd20, 6'd17, 6'd14, 6'd11, 6'd8, 6'd5, 6'd0
    };

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_kind;

    // one row of the directed table: item plus an optional expected word
    typedef struct packed {
        t_in_item    item;
        logic        typed;
        logic [31:0] word;
    } t_dir_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;

    t_rgb      model_palette [NUM_ENTRIES];
    t_cfg      model_cfg;
    t_out_item expected_bytes [$];
    int        mismatch_count = 0;
    int        burst_left     = 0;
    bit        hold_request   = 1'b0;

    always #2 clk = ~clk;

    palette_pixel_format_converter_core #(
        .PALETTE_ENTRIES(NUM_ENTRIES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    // 6-bit dac value widened by repeating its top bits
    function automatic logic [CHAN_W-1:0] dac_to_8(input logic [DAC_W-1:0] v);
        return {v, v[DAC_W-1 -: 2]};
    endfunction

    function automatic void set_entry(input int idx, input int r6, input int g6, input int b6);
        if (idx < NUM_ENTRIES) begin
            model_palette[idx].red   = dac_to_8(DAC_W'(r6));
            model_palette[idx].green = dac_to_8(DAC_W'(g6));
            model_palette[idx].blue  = dac_to_8(DAC_W'(b6));
        end
    endfunction

    // level index of red along the hue circle; green and blue are rotated copies
    function automatic int hue_ramp(input int j);
        if (j < 4) return j;
        if (j < 13) return 4;
        if (j < 16) return 16 - j;
        return 0;
    endfunction

    function automatic void load_vga_palette();
        int hi;
        int g6;
        int p;
        int m;
        int idx;
        int lv [5];
        for (int i = 0; i < NUM_ENTRIES; i++) model_palette[i] = '0;
        // ega colors: 42 per color bit, 21 more for intensity, brown at entry 6
        for (int i = 0; i < 16; i++) begin
            hi = (i >= 8) ? 21 : 0;
            g6 = (i == 6) ? 21 : 42 * ((i >> 1) & 1) + hi;
            set_entry(i, 42 * ((i >> 2) & 1) + hi, g6, 42 * (i & 1) + hi);
        end
        for (int i = 0; i < 16; i++) begin
            g6 = GRAY_DAC[6*i +: 6];
            set_entry(16 + i, g6, g6, g6);
        end
        // three peaks, three saturation floors, 24 hues each
        idx = 32;
        for (int vg = 0; vg < 3; vg++) begin
            p = (vg == 0) ? 63 : (vg == 1) ? 28 : 16;
            for (int sg = 0; sg < 3; sg++) begin
                m = (sg == 0) ? 0 : (sg == 1) ? (p + 1) / 2 : (p * 5 + 3) / 7;
                lv[0] = m;
                lv[1] = m + (p - m + 2) / 4;
                lv[2] = m + (p - m) * 2 / 4;
                lv[3] = m + (p - m) * 3 / 4;
                lv[4] = p;
                for (int k = 0; k < 24; k++) begin
                    set_entry(idx, lv[hue_ramp(k)], lv[hue_ramp((k + 16) % 24)],
                              lv[hue_ramp((k + 8) % 24)]);
                    idx++;
                end
            end
        end
    endfunction

    // rounded scale to the channel maximum, then placed; high bits fall off
    function automatic logic [WORD_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [MAX_W-1:0] mx,
                                                     input logic [SHIFT_W-1:0] sh);
        logic [31:0] s;
        s = (32'(c) * 32'(mx) + 32'd127) / 32'd255;
        return s << sh;
    endfunction

    function automatic void push_word(input logic [31:0] word, input int nbytes,
                                      input logic big);
        t_out_item ob;
        int        pos;
        for (int b = 0; b < nbytes; b++) begin
            pos              = big ? nbytes - 1 - b : b;
            ob.out_byte      = word[8*pos +: 8];
            ob.last_of_pixel = (b == nbytes - 1);
            expected_bytes.push_back(ob);
        end
    endfunction

    // palette update or pixel conversion for one accepted item
    function automatic void predict_item(input t_in_item it);
        t_rgb        e;
        logic [31:0] word;
        int          nbytes;
        if (it.op == OP_WRITE) begin
            set_entry(it.color_index, it.entry_red, it.entry_green, it.entry_blue);
        end else begin
            e = (it.color_index < NUM_ENTRIES) ? model_palette[it.color_index] : '0;
            word = scale_chan(e.red, model_cfg.red_max, model_cfg.red_shift)
                 | scale_chan(e.green, model_cfg.green_max, model_cfg.green_shift)
                 | scale_chan(e.blue, model_cfg.blue_max, model_cfg.blue_shift);
            nbytes = (model_cfg.bpp_mode == BPP_ONE) ? 1 :
                     (model_cfg.bpp_mode == BPP_TWO) ? 2 : 4;
            push_word(word, nbytes, model_cfg.big_endian);
        end
    endfunction

    function automatic t_cfg make_cfg(input logic [MODE_W-1:0] mode, input logic big,
                                      input logic [MAX_W-1:0] rmax,
                                      input logic [MAX_W-1:0] gmax,
                                      input logic [MAX_W-1:0] bmax,
                                      input logic [SHIFT_W-1:0] rsh,
                                      input logic [SHIFT_W-1:0] gsh,
                                      input logic [SHIFT_W-1:0] bsh);
        t_cfg c;
        c.bpp_mode    = mode;
        c.big_endian  = big;
        c.red_max     = rmax;
        c.green_max   = gmax;
        c.blue_max    = bmax;
        c.red_shift   = rsh;
        c.green_shift = gsh;
        c.blue_shift  = bsh;
        return c;
    endfunction

    // channel maximum biased toward the ends of its range
    function automatic logic [MAX_W-1:0] pick_max();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd255;
            3:       return 16'hFFFF;
            default: return MAX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_dir_row dir_row(input logic op, input int idx, input int r6,
                                         input int g6, input int b6, input logic typed,
                                         input logic [31:0] word);
        t_dir_row d;
        d.item.op          = op;
        d.item.color_index = INDEX_W'(idx);
        d.item.entry_red   = DAC_W'(r6);
        d.item.entry_green = DAC_W'(g6);
        d.item.entry_blue  = DAC_W'(b6);
        d.typed            = typed;
        d.word             = word;
        return d;
    endfunction

    // offer one item in bursts with random gaps; predict once it is taken
    task automatic send_item(input t_in_item it, input logic typed, input logic [31:0] word);
        int gap;
        bit took;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        took = 1'b0;
        while (!took) begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        // typed rows are pixels in the reset format: four bytes, low byte first
        if (typed) push_word(word, 4, 1'b0);
        else predict_item(it);
    endtask

    // drain all results, then let any palette write in flight settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic program_format(input t_cfg c);
        write_reg(CFG_BPP_MODE, CFG_DATA_W'(c.bpp_mode));
        write_reg(CFG_BIG_ENDIAN, CFG_DATA_W'(c.big_endian));
        write_reg(CFG_RED_MAX, c.red_max);
        write_reg(CFG_GREEN_MAX, c.green_max);
        write_reg(CFG_BLUE_MAX, c.blue_max);
        write_reg(CFG_RED_SHIFT, CFG_DATA_W'(c.red_shift));
        write_reg(CFG_GREEN_SHIFT, CFG_DATA_W'(c.green_shift));
        write_reg(CFG_BLUE_SHIFT, CFG_DATA_W'(c.blue_shift));
        cfg_wr_en <= 1'b0;
        model_cfg = c;
    endtask

    // result side: compare each taken byte with the oldest expectation
    always @(negedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result item: out_byte %0h last_of_pixel %0b",
                       out_item.out_byte, out_item.last_of_pixel);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_item.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, out_item.out_byte);
                    mismatch_count++;
                end
                if (out_item.last_of_pixel !== want.last_of_pixel) begin
                    $error("last_of_pixel: expected %0b, got %0b",
                           want.last_of_pixel, out_item.last_of_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : stall_pattern
        int          seg_len;
        t_stall_kind seg_kind;
        wait (rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            seg_len  = $urandom_range(4, 60);
            seg_kind = t_stall_kind'($urandom_range(0, 3));
            repeat (seg_len) begin
                @(posedge clk);
                case (seg_kind)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial begin : stimulus
        t_dir_row dir_tab [DIR_ROWS];
        t_cfg     phases [NUM_PHASES];
        t_in_item it;

        dir_tab = '{
            dir_row(OP_PIXEL,   0,  0,  0,  0, 1'b1, 32'h0000_0000),  // black
            dir_row(OP_PIXEL,  15, 63, 63, 63, 1'b1, 32'h00FF_FFFF),  // white
            dir_row(OP_PIXEL,   1,  0,  0,  0, 1'b1, 32'h0000_00AA),  // dark blue
            dir_row(OP_PIXEL, 255,  0,  0,  0, 1'b1, 32'h0000_0000),  // black tail
            dir_row(OP_WRITE, 255, 63, 63, 63, 1'b0, 32'h0),
            dir_row(OP_PIXEL, 255,  0,  0,  0, 1'b1, 32'h00FF_FFFF),
            dir_row(OP_WRITE,   0,  0,  0,  0, 1'b0, 32'h0),
            dir_row(OP_WRITE, 200, 63,  0,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL, 200,  0,  0,  0, 1'b1, 32'h00FF_0000),
            dir_row(OP_WRITE, 201,  0, 63,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL, 201,  0,  0,  0, 1'b1, 32'h0000_FF00),
            dir_row(OP_WRITE, 202,  1,  2,  3, 1'b0, 32'h0),
            dir_row(OP_PIXEL, 202, 63, 63, 63, 1'b0, 32'h0),
            dir_row(OP_PIXEL,  16,  0,  0,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL,  31,  0,  0,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL,  32,  0,  0,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL, 247,  0,  0,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL, 248,  0,  0,  0, 1'b1, 32'h0000_0000),  // black tail
            dir_row(OP_PIXEL, 100,  0,  0,  0, 1'b0, 32'h0),
            dir_row(OP_PIXEL,   6,  0,  0,  0, 1'b0, 32'h0)            // brown
        };

        // reset format, 3-3-2, 5-6-5, unused width code with wide channels,
        // zero maxima, then two random formats
        phases[0] = make_cfg(RST_BPP_MODE, RST_BIG_ENDIAN, RST_CHAN_MAX, RST_CHAN_MAX,
                             RST_CHAN_MAX, RST_RED_SHIFT, RST_GREEN_SHIFT, RST_BLUE_SHIFT);
        phases[1] = make_cfg(BPP_ONE, 1'b0, 16'd7, 16'd7, 16'd3, 5'd5, 5'd2, 5'd0);
        phases[2] = make_cfg(BPP_TWO, 1'b1, 16'd31, 16'd63, 16'd31, 5'd11, 5'd5, 5'd0);
        phases[3] = make_cfg(2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 5'd30, 5'd0);
        phases[4] = make_cfg(BPP_FOUR, 1'b0, 16'd0, 16'd0, 16'd0, 5'd31, 5'd31, 5'd31);
        for (int ph = 5; ph < NUM_PHASES; ph++) begin
            phases[ph] = make_cfg(MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  pick_max(), pick_max(), pick_max(),
                                  SHIFT_W'($urandom_range(0, 31)),
                                  SHIFT_W'($urandom_range(0, 31)),
                                  SHIFT_W'($urandom_range(0, 31)));
        end

        model_cfg = phases[0];
        load_vga_palette();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset format
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].word);
        wait_idle();

        // random items, one format per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            program_format(phases[ph]);
            if (ph == 2) hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                it.op          = ($urandom_range(0, 4) == 0) ? OP_WRITE : OP_PIXEL;
                // half the indexes land in a small window so writes are read back
                it.color_index = ($urandom_range(0, 1) == 0) ?
                                 INDEX_W'($urandom_range(0, 255)) :
                                 INDEX_W'($urandom_range(192, 207));
                it.entry_red   = DAC_W'($urandom_range(0, 63));
                it.entry_green = DAC_W'($urandom_range(0, 63));
                it.entry_blue  = DAC_W'($urandom_range(0, 63));
                send_item(it, 1'b0, 32'h0);
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
